// ===== src/tdor_pkg.sv =====
// Shared types, constants and lookup tables for the torus dimension-order router.
package tdor_pkg;

   // Largest supported grid width; coordinates are sized from it.
   localparam int MAX_WIDTH = 16;
   localparam int COORD_W   = $clog2(MAX_WIDTH);

   // Fixed field widths.
   localparam int ID_W    = 8;
   localparam int GRID_W  = 5;
   localparam int DIR_W   = 3;
   localparam int PROD_W  = COORD_W + GRID_W;
   localparam int SQ_W    = 2 * GRID_W;
   localparam int STEP_W  = GRID_W + 1;
   localparam int CSR_IDX_W = 2;

   // Register reset values.
   localparam logic [GRID_W-1:0] GRID_WIDTH_RESET = GRID_W'(8);
   localparam logic [GRID_W-1:0] EMBED_WIDTH      = GRID_W'(8);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EMBED_MODE = CSR_IDX_W'(1);

   // Direction codes.
   localparam logic [DIR_W-1:0] DIR_XP      = DIR_W'(0);
   localparam logic [DIR_W-1:0] DIR_XM      = DIR_W'(1);
   localparam logic [DIR_W-1:0] DIR_YP      = DIR_W'(2);
   localparam logic [DIR_W-1:0] DIR_YM      = DIR_W'(3);
   localparam logic [DIR_W-1:0] DIR_ARRIVED = DIR_W'(4);

   // Embedding permutation and its inverse.
   localparam logic [2:0] PERM8     [8] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6};
   localparam logic [2:0] PERM8_INV [8] = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd2, 3'd3, 3'd7, 3'd4};

   typedef struct packed {
      logic start;  // transfer accepted: capture ids and start the dividers
      logic init;   // load coordinates and the error flag
      logic load;   // load the next result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;  // coordinate dividers have finished
      logic last;      // the pending result closes the route
   } dp_status_type;

   // Shorter way around a ring; a tie steps backward from an odd coordinate.
   function automatic logic go_forward(input logic [COORD_W-1:0] cur,
                                       input logic [COORD_W-1:0] tgt,
                                       input logic [GRID_W-1:0]  w);
      logic [STEP_W-1:0] diff;
      logic [STEP_W-1:0] fwd;
      logic [STEP_W-1:0] bwd;
      diff = STEP_W'(tgt) + STEP_W'(w) - STEP_W'(cur);
      fwd  = (diff >= STEP_W'(w)) ? diff - STEP_W'(w) : diff;
      bwd  = STEP_W'(w) - fwd;
      if (fwd < bwd) begin
         return 1'b1;
      end else if (bwd < fwd) begin
         return 1'b0;
      end
      return ~cur[0];
   endfunction

   // One hop along a ring of w nodes, with wraparound.
   function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                     input logic               fwd,
                                                     input logic [GRID_W-1:0]  w);
      logic [STEP_W-1:0] inc;
      inc = STEP_W'(c) + STEP_W'(1);
      if (fwd) begin
         return (inc == STEP_W'(w)) ? COORD_W'(0) : COORD_W'(inc);
      end
      return (c == COORD_W'(0)) ? COORD_W'(w - GRID_W'(1)) : c - COORD_W'(1);
   endfunction

endpackage

// ===== src/tdor_div.sv =====
// Restoring divider, one quotient bit per cycle, used to split a node index into coordinates.
module tdor_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tdor_pkg::ID_W-1:0]    dividend,
   input  logic [tdor_pkg::GRID_W-1:0]  divisor,
   output logic                         done,
   output logic [tdor_pkg::ID_W-1:0]    quotient,
   output logic [tdor_pkg::GRID_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(tdor_pkg::ID_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tdor_pkg::ID_W-1:0]   quot_ff, quot_in;
   logic [tdor_pkg::GRID_W-1:0] rem_ff, rem_in;
   logic [tdor_pkg::GRID_W-1:0] dsr_ff, dsr_in;
   logic [tdor_pkg::GRID_W:0]   trial;
   logic                        qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quot_ff[tdor_pkg::ID_W-1]};
      qbit    = (trial >= {1'b0, dsr_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = qbit ? tdor_pkg::GRID_W'(trial - {1'b0, dsr_ff})
                        : tdor_pkg::GRID_W'(trial);
         quot_in = {quot_ff[tdor_pkg::ID_W-2:0], qbit};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(tdor_pkg::ID_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/tdor_datapath.sv =====
// Datapath: configuration registers, coordinate registers, hop stepping and result register.
module tdor_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [tdor_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tdor_pkg::GRID_W-1:0]            csr_wdata,
   input  logic [tdor_pkg::ID_W-1:0]              req_source_node,
   input  logic [tdor_pkg::ID_W-1:0]              req_dest_node,
   input  tdor_pkg::dp_cmd_type                   cmd,
   output tdor_pkg::dp_status_type                status,
   output logic [tdor_pkg::ID_W-1:0]              rsp_hop_node,
   output logic [tdor_pkg::DIR_W-1:0]             rsp_out_dir,
   output logic                                   rsp_is_last,
   output logic                                   rsp_bad_request
);

   localparam int CW = tdor_pkg::COORD_W;

   logic [tdor_pkg::GRID_W-1:0] grid_width_ff, grid_width_in;
   logic                        embed_mode_ff, embed_mode_in;
   logic [tdor_pkg::ID_W-1:0]   src_ff, src_in;
   logic [tdor_pkg::ID_W-1:0]   dst_ff, dst_in;
   logic                        bad_ff, bad_in;
   logic [CW-1:0]               x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]               dx_ff, dx_in, dy_ff, dy_in;
   logic [tdor_pkg::ID_W-1:0]   hop_ff, hop_in;
   logic [tdor_pkg::DIR_W-1:0]  dir_ff, dir_in;
   logic                        last_ff, last_in;
   logic                        badr_ff, badr_in;

   logic [tdor_pkg::ID_W-1:0]   src_phys, dst_phys;
   logic                        src_done, dst_done;
   logic [tdor_pkg::ID_W-1:0]   src_quot, dst_quot;
   logic [tdor_pkg::GRID_W-1:0] src_rem, dst_rem;
   logic [tdor_pkg::SQ_W-1:0]   grid_sq;
   logic                        check_bad;
   logic [tdor_pkg::PROD_W-1:0] row_base;
   logic [tdor_pkg::ID_W-1:0]   cur_node;
   logic                        x_move, y_move, fx, fy;

   // In embedding mode the permutation is applied to both coordinates of the id.
   always_comb begin
      if (embed_mode_ff) begin
         src_phys = tdor_pkg::ID_W'({tdor_pkg::PERM8[req_source_node[5:3]],
                                     tdor_pkg::PERM8[req_source_node[2:0]]});
         dst_phys = tdor_pkg::ID_W'({tdor_pkg::PERM8[req_dest_node[5:3]],
                                     tdor_pkg::PERM8[req_dest_node[2:0]]});
      end else begin
         src_phys = req_source_node;
         dst_phys = req_dest_node;
      end
   end

   tdor_div u_src_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (src_phys),
      .divisor   (grid_width_ff),
      .done      (src_done),
      .quotient  (src_quot),
      .remainder (src_rem)
   );

   tdor_div u_dst_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (dst_phys),
      .divisor   (grid_width_ff),
      .done      (dst_done),
      .quotient  (dst_quot),
      .remainder (dst_rem)
   );

   assign grid_sq   = tdor_pkg::SQ_W'(grid_width_ff) * tdor_pkg::SQ_W'(grid_width_ff);
   assign check_bad = (grid_width_ff < tdor_pkg::GRID_W'(2))
                   || (tdor_pkg::SQ_W'(grid_width_ff) > tdor_pkg::SQ_W'(tdor_pkg::MAX_WIDTH))
                   || (tdor_pkg::SQ_W'(src_ff) >= grid_sq)
                   || (tdor_pkg::SQ_W'(dst_ff) >= grid_sq)
                   || (embed_mode_ff && (grid_width_ff != tdor_pkg::EMBED_WIDTH));

   // Logical id of the current coordinates.
   assign row_base = tdor_pkg::PROD_W'(y_ff) * tdor_pkg::PROD_W'(grid_width_ff);
   always_comb begin
      if (embed_mode_ff) begin
         cur_node = tdor_pkg::ID_W'({tdor_pkg::PERM8_INV[3'(y_ff)],
                                     tdor_pkg::PERM8_INV[3'(x_ff)]});
      end else begin
         cur_node = tdor_pkg::ID_W'(row_base + tdor_pkg::PROD_W'(x_ff));
      end
   end

   assign x_move = (x_ff != dx_ff);
   assign y_move = (y_ff != dy_ff);
   assign fx     = tdor_pkg::go_forward(x_ff, dx_ff, grid_width_ff);
   assign fy     = tdor_pkg::go_forward(y_ff, dy_ff, grid_width_ff);

   assign status.div_done = src_done & dst_done;
   assign status.last     = bad_ff | (~x_move & ~y_move);

   always_comb begin
      grid_width_in = grid_width_ff;
      embed_mode_in = embed_mode_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      bad_in        = bad_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      hop_in        = hop_ff;
      dir_in        = dir_ff;
      last_in       = last_ff;
      badr_in       = badr_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            tdor_pkg::CSR_GRID_WIDTH: grid_width_in = csr_wdata;
            tdor_pkg::CSR_EMBED_MODE: embed_mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.start) begin
         src_in = req_source_node;
         dst_in = req_dest_node;
      end

      if (cmd.init) begin
         bad_in = check_bad;
         x_in   = CW'(src_rem);
         y_in   = CW'(src_quot);
         dx_in  = CW'(dst_rem);
         dy_in  = CW'(dst_quot);
      end

      if (cmd.load) begin
         if (bad_ff) begin
            hop_in  = '0;
            dir_in  = tdor_pkg::DIR_ARRIVED;
            last_in = 1'b1;
            badr_in = 1'b1;
         end else if (x_move) begin
            hop_in  = cur_node;
            dir_in  = fx ? tdor_pkg::DIR_XP : tdor_pkg::DIR_XM;
            last_in = 1'b0;
            badr_in = 1'b0;
            x_in    = tdor_pkg::step_coord(x_ff, fx, grid_width_ff);
         end else if (y_move) begin
            hop_in  = cur_node;
            dir_in  = fy ? tdor_pkg::DIR_YP : tdor_pkg::DIR_YM;
            last_in = 1'b0;
            badr_in = 1'b0;
            y_in    = tdor_pkg::step_coord(y_ff, fy, grid_width_ff);
         end else begin
            hop_in  = dst_ff;
            dir_in  = tdor_pkg::DIR_ARRIVED;
            last_in = 1'b1;
            badr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= tdor_pkg::GRID_WIDTH_RESET;
         embed_mode_ff <= 1'b0;
      end else begin
         grid_width_ff <= grid_width_in;
         embed_mode_ff <= embed_mode_in;
      end
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      bad_ff  <= bad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      hop_ff  <= hop_in;
      dir_ff  <= dir_in;
      last_ff <= last_in;
      badr_ff <= badr_in;
   end

   assign rsp_hop_node    = hop_ff;
   assign rsp_out_dir     = dir_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_bad_request = badr_ff;

endmodule

// ===== src/tdor_ctrl.sv =====
// Controller state machine: request handshake, divider sequencing and result valid.
module tdor_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tdor_pkg::dp_cmd_type    cmd,
   input  tdor_pkg::dp_status_type status
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_ROUTE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.init = 1'b1;
               state_in = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (~rsp_valid_ff | rsp_ready))
      else $error("result loaded over an unread result");

   a_accept_divides: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIVIDE))
      else $error("accepted request did not start division");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("final result did not return to idle");
`endif

endmodule

// ===== src/torus_dimension_order_route.sv =====
// Top level of the dimension-order router for a square 2D torus.
//
//   Channel  Direction  Handshake                     Payload
//   req      in         req_valid / req_ready         req_source_node, req_dest_node
//   rsp      out        rsp_valid / rsp_ready         rsp_hop_node, rsp_out_dir,
//                                                     rsp_is_last, rsp_bad_request
//   csr      in         csr_write_enable (no wait)    csr_index, csr_wdata
//
// A request transfer starts two restoring dividers that split the source and
// destination indexes into coordinates, one quotient bit a cycle, before the
// route begins. Results then leave at one per cycle while the consumer keeps
// rsp_ready high: a request yields one result per hop plus the arrival (up to
// 17 at width 16), and an error request a single result.
// req_ready returns as soon as the last result is in the output register, so
// the next request is taken while that result still waits for its transfer.
// Reset is synchronous; it sets grid_width to 8 and embed_mode to 0.
// A stalled consumer simply holds the route where it is.
module torus_dimension_order_route (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [tdor_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdor_pkg::GRID_W-1:0]        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tdor_pkg::ID_W-1:0]          req_source_node,
   input  logic [tdor_pkg::ID_W-1:0]          req_dest_node,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tdor_pkg::ID_W-1:0]          rsp_hop_node,
   output logic [tdor_pkg::DIR_W-1:0]         rsp_out_dir,
   output logic                               rsp_is_last,
   output logic                               rsp_bad_request
);

   // Commands flow from the controller to the datapath; status flows back.
   tdor_pkg::dp_cmd_type    cmd;
   tdor_pkg::dp_status_type status;

   tdor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the configuration registers, the coordinate walk and
   // the output register whose contents are offered on the rsp channel.
   tdor_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_source_node  (req_source_node),
      .req_dest_node    (req_dest_node),
      .cmd              (cmd),
      .status           (status),
      .rsp_hop_node     (rsp_hop_node),
      .rsp_out_dir      (rsp_out_dir),
      .rsp_is_last      (rsp_is_last),
      .rsp_bad_request  (rsp_bad_request)
   );

endmodule

// ===== tb/torus_dimension_order_route_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the torus dimension-order router, with random stimulus and idling.
module torus_dimension_order_route_test;

   // The watchdog must outlast the long receiver hold plus a long sender gap.
   localparam int STALL_LIMIT     = 2000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 40;

   // Register indexes beyond the two real registers; writes to them are dropped.
   localparam logic [tdor_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = tdor_pkg::CSR_IDX_W'(2);
   localparam logic [tdor_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = tdor_pkg::CSR_IDX_W'(3);

   // Embedding permutation and its inverse, entry i at bits [3*i +: 3].
   localparam logic [23:0] EMBED_PERM =
      {3'd6, 3'd3, 3'd2, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0};
   localparam logic [23:0] EMBED_INV =
      {3'd4, 3'd7, 3'd3, 3'd2, 3'd6, 3'd5, 3'd1, 3'd0};

   // One result of a route as the block should present it.
   typedef struct packed {
      logic [tdor_pkg::ID_W-1:0]  node;
      logic [tdor_pkg::DIR_W-1:0] dir;
      logic                       last;
      logic                       bad;
   } route_hop_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [tdor_pkg::CSR_IDX_W-1:0] csr_index        = '0;
   logic [tdor_pkg::GRID_W-1:0]    csr_wdata        = '0;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [tdor_pkg::ID_W-1:0]      req_source_node  = '0;
   logic [tdor_pkg::ID_W-1:0]      req_dest_node    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic [tdor_pkg::ID_W-1:0]      rsp_hop_node;
   logic [tdor_pkg::DIR_W-1:0]     rsp_out_dir;
   logic                           rsp_is_last;
   logic                           rsp_bad_request;

   // Shadow of the configuration registers, updated as each write is issued.
   int unsigned cfg_grid_width = 8;
   logic        cfg_embed      = 1'b0;

   // Hops still owed by the block, oldest first.
   route_hop_type hops_due[$];

   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   bit  req_gaps_on    = 1'b1;
   bit  rsp_gaps_on    = 1'b1;
   bit  hold_rsp       = 1'b0;

   torus_dimension_order_route u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_node  (req_source_node),
      .req_dest_node    (req_dest_node),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hop_node     (rsp_hop_node),
      .rsp_out_dir      (rsp_out_dir),
      .rsp_is_last      (rsp_is_last),
      .rsp_bad_request  (rsp_bad_request)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle stretches are mostly short, now and then much longer.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Appends one hop at the tail of the owed list.
   function automatic void owe_hop(input route_hop_type hop);
      hops_due = {hops_due, hop};
   endfunction

   // Shorter way around a ring; on a tie an odd coordinate steps backward.
   function automatic bit shorter_is_forward(input int unsigned cur, input int unsigned tgt,
                                             input int unsigned w);
      int unsigned fwd_dist;
      int unsigned bwd_dist;
      fwd_dist = (tgt + w - cur) % w;
      bwd_dist = w - fwd_dist;
      if (fwd_dist < bwd_dist) begin
         return 1'b1;
      end
      if (bwd_dist < fwd_dist) begin
         return 1'b0;
      end
      return (cur % 2) == 0;
   endfunction

   // Logical id of the node at physical coordinates (x, y).
   function automatic logic [tdor_pkg::ID_W-1:0] node_id(input int unsigned x,
                                                         input int unsigned y,
                                                         input int unsigned w);
      if (cfg_embed) begin
         return tdor_pkg::ID_W'(EMBED_INV[3*y +: 3] * 8 + EMBED_INV[3*x +: 3]);
      end
      return tdor_pkg::ID_W'(y * w + x);
   endfunction

   // Work out every hop of one request under the current configuration and queue them.
   function automatic void plan_route(input logic [tdor_pkg::ID_W-1:0] src,
                                      input logic [tdor_pkg::ID_W-1:0] dst);
      int unsigned               w;
      int unsigned               x;
      int unsigned               y;
      int unsigned               dx;
      int unsigned               dy;
      bit                        fwd;
      logic [tdor_pkg::ID_W-1:0] here;
      w = cfg_grid_width;
      if (w < 2 || w > tdor_pkg::MAX_WIDTH || src >= w * w || dst >= w * w ||
          (cfg_embed && w != 8)) begin
         owe_hop('{tdor_pkg::ID_W'(0), tdor_pkg::DIR_ARRIVED, 1'b1, 1'b1});
         return;
      end
      if (cfg_embed) begin
         x  = 32'(EMBED_PERM[3*src[2:0] +: 3]);
         y  = 32'(EMBED_PERM[3*src[5:3] +: 3]);
         dx = 32'(EMBED_PERM[3*dst[2:0] +: 3]);
         dy = 32'(EMBED_PERM[3*dst[5:3] +: 3]);
      end else begin
         x  = src % w;
         y  = src / w;
         dx = dst % w;
         dy = dst / w;
      end
      here = src;
      // All X hops first, then all Y hops.
      while (x != dx) begin
         fwd = shorter_is_forward(x, dx, w);
         owe_hop('{here, fwd ? tdor_pkg::DIR_XP : tdor_pkg::DIR_XM, 1'b0, 1'b0});
         x = fwd ? (x + 1) % w : (x + w - 1) % w;
         here = node_id(x, y, w);
      end
      while (y != dy) begin
         fwd = shorter_is_forward(y, dy, w);
         owe_hop('{here, fwd ? tdor_pkg::DIR_YP : tdor_pkg::DIR_YM, 1'b0, 1'b0});
         y = fwd ? (y + 1) % w : (y + w - 1) % w;
         here = node_id(x, y, w);
      end
      owe_hop('{dst, tdor_pkg::DIR_ARRIVED, 1'b1, 1'b0});
   endfunction

   // Offer one request and wait for its transfer. Valid stays high when no gap
   // follows, so the caller either sends again at once or lowers valid itself.
   task automatic send_route(input logic [tdor_pkg::ID_W-1:0] src,
                             input logic [tdor_pkg::ID_W-1:0] dst);
      req_valid       <= 1'b1;
      req_source_node <= src;
      req_dest_node   <= dst;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      // The configuration cannot change while requests are in flight, so the
      // whole route is known at the moment of the transfer.
      plan_route(src, dst);
      if (req_gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Stop offering requests and let every owed result come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (hops_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tdor_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tdor_pkg::GRID_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         tdor_pkg::CSR_GRID_WIDTH: cfg_grid_width = 32'(data);
         tdor_pkg::CSR_EMBED_MODE: cfg_embed = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reconfigure once the block is idle. Upper bits of the mode write are noise.
   task automatic set_grid(input int unsigned w, input logic embed);
      wait_drained();
      write_csr(tdor_pkg::CSR_GRID_WIDTH, tdor_pkg::GRID_W'(w));
      write_csr(tdor_pkg::CSR_EMBED_MODE, {4'($urandom), embed});
   endtask

   // Reset values: width 8, identity mapping.
   task automatic test_same_node();
      send_route(8'd0, 8'd0);
      send_route(8'd63, 8'd63);
      send_route(8'd27, 8'd27);
   endtask

   task automatic test_ring_ties();
      send_route(8'd0, 8'd4);   // X tie from an even coordinate goes forward
      send_route(8'd1, 8'd5);   // X tie from an odd coordinate goes backward
      send_route(8'd0, 8'd32);  // Y tie from an even row
      send_route(8'd8, 8'd40);  // Y tie from an odd row
      send_route(8'd63, 8'd0);  // both rings wrap forward
   endtask

   task automatic test_id_range();
      send_route(8'd64, 8'd0);
      send_route(8'd0, 8'd255);
   endtask

   task automatic test_width_extremes();
      set_grid(16, 1'b0);
      send_route(8'd0, 8'd255);
      send_route(8'd255, 8'd0);
      send_route(8'd0, 8'd136);
      set_grid(2, 1'b0);
      send_route(8'd0, 8'd3);
      send_route(8'd3, 8'd0);
      send_route(8'd2, 8'd4);
   endtask

   // Widths outside 2..16 reject every request.
   task automatic test_bad_width();
      set_grid(0, 1'b0);
      send_route(8'd0, 8'd0);
      set_grid(1, 1'b0);
      send_route(8'd0, 8'd0);
      set_grid(17, 1'b0);
      send_route(8'd0, 8'd1);
      set_grid(31, 1'b0);
      send_route(8'd0, 8'd0);
   endtask

   task automatic test_embedding();
      set_grid(8, 1'b1);
      send_route(8'd0, 8'd63);
      send_route(8'd9, 8'd54);
      send_route(8'd12, 8'd12);
      send_route(8'd64, 8'd1);
      set_grid(16, 1'b1);
      send_route(8'd0, 8'd0);
   endtask

   // Writes to the spare indexes must leave both registers alone.
   task automatic test_spare_index();
      set_grid(8, 1'b0);
      write_csr(CSR_SPARE_LO, 5'd0);
      write_csr(CSR_SPARE_HI, 5'h1f);
      send_route(8'd0, 8'd63);
   endtask

   task automatic test_random_routes();
      int unsigned               phase;
      int unsigned               w;
      int unsigned               lim;
      int unsigned               count;
      bit                        bad_cfg;
      logic                      embed;
      logic [tdor_pkg::ID_W-1:0] src;
      logic [tdor_pkg::ID_W-1:0] dst;
      for (phase = 0; phase < 22; phase++) begin
         bad_cfg = 1'b0;
         case (phase % 6)
            0: begin
               w = 16;
               embed = 1'b0;
            end
            1: begin
               w = 2;
               embed = 1'b0;
            end
            2: begin
               w = 8;
               embed = 1'b1;
            end
            3: begin
               bad_cfg = 1'b1;
               embed = 1'b0;
               w = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            end
            4: begin
               // Embedding with a width from 2 to 16 other than 8.
               bad_cfg = 1'b1;
               embed = 1'b1;
               w = $urandom_range(2, 15);
               if (w >= 8) begin
                  w++;
               end
            end
            default: begin
               w = $urandom_range(2, 16);
               embed = 1'b0;
            end
         endcase
         set_grid(w, embed);
         // Some phases run without idling on one side or both.
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         count = bad_cfg ? 6 : 26;
         lim = bad_cfg ? 255 : w * w - 1;
         repeat (count) begin
            // Mostly ids on the grid, so most requests produce real routes.
            src = ($urandom_range(0, 19) < 17) ? tdor_pkg::ID_W'($urandom_range(0, lim))
                                               : tdor_pkg::ID_W'($urandom_range(0, 255));
            dst = ($urandom_range(0, 19) < 17) ? tdor_pkg::ID_W'($urandom_range(0, lim))
                                               : tdor_pkg::ID_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
               dst = src;
            end
            send_route(src, dst);
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // block fills and has to hold off its input.
   task automatic test_output_backpressure();
      set_grid(16, 1'b0);
      req_gaps_on = 1'b0;
      hold_rsp = 1'b1;
      repeat (16) begin
         send_route(tdor_pkg::ID_W'($urandom_range(0, 255)),
                    tdor_pkg::ID_W'($urandom_range(0, 255)));
      end
      req_gaps_on = 1'b1;
   endtask

   // Receiver readiness: mostly ready, random gaps, and the long hold on request.
   initial begin : rsp_ready_driver
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every result transfer is checked against the oldest owed hop.
   always @(posedge clock) begin : rsp_check
      route_hop_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hops_due.size() == 0) begin
            $error("result with none expected: hop_node %0d, out_dir %0d",
                   rsp_hop_node, rsp_out_dir);
            mismatch_count++;
         end else begin
            want = hops_due[0];
            hops_due.delete(0);
            if (rsp_hop_node !== want.node) begin
               $error("hop_node: expected %0d, got %0d", want.node, rsp_hop_node);
               mismatch_count++;
            end
            if (rsp_out_dir !== want.dir) begin
               $error("out_dir: expected %0d, got %0d", want.dir, rsp_out_dir);
               mismatch_count++;
            end
            if (rsp_is_last !== want.last) begin
               $error("is_last: expected %0d, got %0d", want.last, rsp_is_last);
               mismatch_count++;
            end
            if (rsp_bad_request !== want.bad) begin
               $error("bad_request: expected %0d, got %0d", want.bad, rsp_bad_request);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither channel completes a transfer for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : main_sequence
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_same_node();
      test_ring_ties();
      test_id_range();
      test_width_extremes();
      test_bad_width();
      test_embedding();
      test_spare_index();
      test_random_routes();
      test_output_backpressure();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
